@@ rtl/ltsp_pkg.sv @@
// Package for the lexical unit tag splitter.
// Types, byte codes and command/status structs shared by ltsp_ctrl, ltsp_dp and the core.
// No dependencies.
`default_nettype none

package ltsp_pkg;

    localparam int TAG_BUF_DEPTH_DEF = 32;
    localparam int BYTE_W            = 8;

    localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'h24;
    localparam logic [BYTE_W-1:0] CH_CARET     = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LT        = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_HASH      = 8'h23;
    localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BRACKET = 2'd1,
        STATUS_WORD    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PARSE_TOP,
        PARSE_TOP_ESC,
        PARSE_BRACKET,
        PARSE_BRACKET_ESC,
        PARSE_WORD
    } parse_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PUSH2,
        SEQ_PUSH3,
        SEQ_FLUSH,
        SEQ_DOLLAR
    } seq_t;

    typedef enum logic [1:0] {
        EMIT_BYTE,
        EMIT_RAM,
        EMIT_DOLLAR,
        EMIT_STATUS
    } emit_sel_t;

    typedef enum logic [1:0] {
        PUSH_BYTE,
        PUSH_DOLLAR,
        PUSH_SPACE,
        PUSH_CARET
    } push_sel_t;

    typedef struct packed {
        logic      emit;
        emit_sel_t emit_sel;
        status_t   status;
        logic      last;
        logic      push;
        push_sel_t push_sel;
        logic      clear_word;
        logic      reset_buf;
        logic      flush_start;
        logic      flush_next;
        logic      clear_count;
    } ltsp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic flush_more;
    } ltsp_stat_t;

endpackage

`default_nettype wire

@@ rtl/ltsp_if.sv @@
// Handshake channel interfaces for the tag splitter: input bytes and results.
// Stand-alone; no package dependency.
`default_nettype none

interface ltsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ltsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_of_run;
    logic [1:0] status;
    logic       truncated;

    modport source (output valid, output out_byte, output is_data, output last_of_run,
                    output status, output truncated, input ready);
    modport sink   (input valid, input out_byte, input is_data, input last_of_run,
                    input status, input truncated, output ready);
endinterface

`default_nettype wire

@@ rtl/ltsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ltsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ltsp_ctrl.sv @@
// Controller: parse state, tag span flag and the push/flush sequencer.
// Depends on ltsp_pkg; drives ltsp_dp through ltsp_cmd_t.
`default_nettype none

module ltsp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_eos,
    output logic                       in_ready,
    input  wire ltsp_pkg::ltsp_stat_t  stat,
    output ltsp_pkg::ltsp_cmd_t        cmd
);
    import ltsp_pkg::*;

    parse_t parse_reg, parse_next;
    seq_t   seq_reg, seq_next;
    logic   span_reg, span_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg <= PARSE_TOP;
            seq_reg   <= SEQ_IDLE;
            span_reg  <= 1'b0;
        end
        else
        begin
            parse_reg <= parse_next;
            seq_reg   <= seq_next;
            span_reg  <= span_next;
        end
    end

    assign in_ready = (seq_reg == SEQ_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        parse_next = parse_reg;
        seq_next   = seq_reg;
        span_next  = span_reg;
        cmd        = '0;
        cmd.emit_sel = EMIT_BYTE;
        cmd.status   = STATUS_OK;
        cmd.push_sel = PUSH_BYTE;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (accept && in_eos)
                begin
                    if (parse_reg == PARSE_BRACKET || parse_reg == PARSE_BRACKET_ESC)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_STATUS;
                        cmd.status   = STATUS_BRACKET;
                        cmd.last     = 1'b1;
                    end
                    else if (parse_reg == PARSE_WORD)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_STATUS;
                        cmd.status   = STATUS_WORD;
                        cmd.last     = 1'b1;
                    end
                    cmd.reset_buf = 1'b1;
                    parse_next    = PARSE_TOP;
                    span_next     = 1'b0;
                end
                else if (accept)
                begin
                    unique case (parse_reg)
                        PARSE_TOP:
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                            if (in_byte == CH_LBRACKET)
                            begin
                                parse_next = PARSE_BRACKET;
                            end
                            else if (in_byte == CH_BACKSLASH)
                            begin
                                parse_next = PARSE_TOP_ESC;
                            end
                            else if (in_byte == CH_CARET)
                            begin
                                parse_next     = PARSE_WORD;
                                span_next      = 1'b0;
                                cmd.clear_word = 1'b1;
                            end
                        end
                        PARSE_TOP_ESC:
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            parse_next = PARSE_TOP;
                        end
                        PARSE_BRACKET:
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                            if (in_byte == CH_RBRACKET)
                            begin
                                parse_next = PARSE_TOP;
                            end
                            else if (in_byte == CH_BACKSLASH)
                            begin
                                parse_next = PARSE_BRACKET_ESC;
                            end
                        end
                        PARSE_BRACKET_ESC:
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            parse_next = PARSE_BRACKET;
                        end
                        PARSE_WORD:
                        begin
                            if (in_byte == CH_DOLLAR)
                            begin
                                parse_next = PARSE_TOP;
                                span_next  = 1'b0;
                                if (stat.count_zero)
                                begin
                                    cmd.emit     = 1'b1;
                                    cmd.emit_sel = EMIT_DOLLAR;
                                    cmd.last     = 1'b1;
                                end
                                else
                                begin
                                    cmd.flush_start = 1'b1;
                                    seq_next        = SEQ_FLUSH;
                                end
                            end
                            else
                            begin
                                if (in_byte == CH_LT && !span_reg)
                                begin
                                    span_next = 1'b1;
                                end
                                else if (in_byte == CH_HASH && span_reg)
                                begin
                                    span_next = 1'b0;
                                end
                                if (span_next)
                                begin
                                    cmd.push = 1'b1;
                                    if (in_byte == CH_PLUS)
                                    begin
                                        cmd.push_sel = PUSH_DOLLAR;
                                        seq_next     = SEQ_PUSH2;
                                    end
                                end
                                else
                                begin
                                    cmd.emit = 1'b1;
                                    cmd.last = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            parse_next = PARSE_TOP;
                        end
                    endcase
                end
            end
            SEQ_PUSH2:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_SPACE;
                seq_next     = SEQ_PUSH3;
            end
            SEQ_PUSH3:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_CARET;
                seq_next     = SEQ_IDLE;
            end
            SEQ_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_RAM;
                    if (stat.flush_more)
                    begin
                        cmd.flush_next = 1'b1;
                    end
                    else
                    begin
                        seq_next = SEQ_DOLLAR;
                    end
                end
            end
            SEQ_DOLLAR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EMIT_DOLLAR;
                    cmd.last        = 1'b1;
                    cmd.clear_count = 1'b1;
                    seq_next        = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ltsp_dp.sv @@
// Datapath: tag buffer RAM, fill count, overflow flag, flush index, output register.
// Depends on ltsp_pkg and ltsp_ram; commanded by ltsp_ctrl.
`default_nettype none

module ltsp_dp #(
    parameter int TAG_BUFFER_DEPTH = ltsp_pkg::TAG_BUF_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           in_byte,
    input  wire ltsp_pkg::ltsp_cmd_t  cmd,
    output ltsp_pkg::ltsp_stat_t      stat,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [7:0]                out_byte,
    output logic                      out_is_data,
    output logic                      out_last,
    output logic [1:0]                out_status,
    output logic                      out_truncated
);
    import ltsp_pkg::*;

    localparam int CNT_W  = $clog2(TAG_BUFFER_DEPTH + 1);
    localparam int ADDR_W = $clog2(TAG_BUFFER_DEPTH);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              data_reg, data_next;
    logic              last_reg, last_next;
    status_t           status_reg, status_next;
    logic              trunc_reg, trunc_next;

    logic              has_room;
    logic              ram_we;
    logic [BYTE_W-1:0] push_byte;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign has_room = count_reg < CNT_W'(TAG_BUFFER_DEPTH);
    assign ram_we   = cmd.push && has_room;
    assign ram_re   = cmd.flush_start || cmd.flush_next;
    assign ram_raddr = cmd.flush_start ? '0 : idx_reg[ADDR_W-1:0];

    always_comb
    begin
        unique case (cmd.push_sel)
            PUSH_BYTE:   push_byte = in_byte;
            PUSH_DOLLAR: push_byte = CH_DOLLAR;
            PUSH_SPACE:  push_byte = CH_SPACE;
            PUSH_CARET:  push_byte = CH_CARET;
            default:     push_byte = in_byte;
        endcase
    end

    ltsp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAG_BUFFER_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (push_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.out_free   = !valid_reg || out_ready;
    assign stat.count_zero = (count_reg == '0);
    assign stat.flush_more = idx_reg < count_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        if (cmd.clear_word || cmd.reset_buf)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            if (has_room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.flush_start)
        begin
            idx_next = CNT_W'(1);
        end
        else if (cmd.flush_next)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        valid_next  = valid_reg && !out_ready;
        byte_next   = byte_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        status_next = status_reg;
        trunc_next  = trunc_reg;
        if (cmd.emit)
        begin
            valid_next  = 1'b1;
            data_next   = 1'b1;
            last_next   = cmd.last;
            status_next = cmd.status;
            trunc_next  = cmd.clear_word ? 1'b0 : ovf_reg;
            unique case (cmd.emit_sel)
                EMIT_BYTE:   byte_next = in_byte;
                EMIT_RAM:    byte_next = ram_rdata;
                EMIT_DOLLAR: byte_next = CH_DOLLAR;
                EMIT_STATUS:
                begin
                    byte_next = '0;
                    data_next = 1'b0;
                end
                default:     byte_next = in_byte;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        trunc_reg  <= trunc_next;
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_is_data   = data_reg;
    assign out_last      = last_reg;
    assign out_status    = status_reg;
    assign out_truncated = trunc_reg;

endmodule

`default_nettype wire

@@ rtl/lexical_unit_tag_splitter_core.sv @@
// Tag splitter byte filter: top level joining controller and datapath.
// Input channel din carries in_byte and end_of_stream; output channel dout
// carries out_byte, is_data, last_of_run, status and truncated.
// Results appear in the output register the cycle after the byte is taken.
// An ordinary byte is taken every cycle while the output is free. A '+'
// inside a tag span buffers '$', space and '^' through the single RAM
// write port: one as it is taken, then one each in SEQ_PUSH2 and SEQ_PUSH3.
// A '$' closing a word with an empty tag buffer is emitted directly; else
// it starts the RAM read; SEQ_FLUSH drains the tags, SEQ_DOLLAR emits '$'.
// din.ready is low while such a sequence runs and while a result is held
// in the output register and dout.ready is low; the held result stays
// stable until taken, and the drain simply pauses.
// Reset returns the parser to top level with an empty tag buffer and no
// overflow; the buffer RAM itself is not cleared, only entries below the
// fill count are ever read. An end-of-stream item returns to the same state.
// Depends on ltsp_pkg, ltsp_if, ltsp_ram, ltsp_ctrl, ltsp_dp.
`default_nettype none

module lexical_unit_tag_splitter_core #(
    parameter int TAG_BUFFER_DEPTH = ltsp_pkg::TAG_BUF_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ltsp_in_if.sink    din,
    ltsp_out_if.source dout
);
    import ltsp_pkg::*;

    ltsp_cmd_t  cmd;
    ltsp_stat_t stat;

    ltsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_byte  (din.in_byte),
        .in_eos   (din.end_of_stream),
        .in_ready (din.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ltsp_dp #(
        .TAG_BUFFER_DEPTH (TAG_BUFFER_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (din.in_byte),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (dout.ready),
        .out_valid     (dout.valid),
        .out_byte      (dout.out_byte),
        .out_is_data   (dout.is_data),
        .out_last      (dout.last_of_run),
        .out_status    (dout.status),
        .out_truncated (dout.truncated)
    );

endmodule

`default_nettype wire

@@ verif/ltsp_result_monitor.sv @@
// Result monitor for lexical_unit_tag_splitter_core: watches both channels,
// predicts every result from the accepted input bytes and compares in order.
// Depends on ltsp_pkg and the ltsp_in_if / ltsp_out_if interfaces.
module ltsp_result_monitor #(
    parameter int TAG_DEPTH = ltsp_pkg::TAG_BUF_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ltsp_in_if   din,
    ltsp_out_if  dout,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ltsp_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       last;
        status_t    status;
        logic       truncated;
    } filter_result_t;

    filter_result_t expected_results[$];

    parse_t     word_state;
    logic       span_open;
    logic [7:0] tag_store [0:TAG_DEPTH-1];
    int         tag_fill;
    logic       tag_overflow;

    task automatic clear_parser();
        word_state   = PARSE_TOP;
        span_open    = 1'b0;
        tag_fill     = 0;
        tag_overflow = 1'b0;
    endtask

    task automatic queue_result(input logic [7:0] b, input logic data, input status_t st);
        filter_result_t r;
        r.data_byte = b;
        r.is_data   = data;
        r.last      = 1'b0;
        r.status    = st;
        r.truncated = tag_overflow;
        expected_results.push_back(r);
    endtask

    task automatic store_tag_byte(input logic [7:0] b);
        if (tag_fill < TAG_DEPTH)
        begin
            tag_store[tag_fill] = b;
            tag_fill++;
        end
        else
        begin
            tag_overflow = 1'b1;
        end
    endtask

    task automatic predict_filter_output(input logic [7:0] b, input logic eos);
        int first;
        first = expected_results.size();
        if (eos)
        begin
            if (word_state == PARSE_BRACKET || word_state == PARSE_BRACKET_ESC)
                queue_result(8'h00, 1'b0, STATUS_BRACKET);
            else if (word_state == PARSE_WORD)
                queue_result(8'h00, 1'b0, STATUS_WORD);
            clear_parser();
        end
        else
        begin
            case (word_state)
                PARSE_TOP:
                begin
                    if (b == CH_CARET)
                    begin
                        tag_overflow = 1'b0;
                        span_open    = 1'b0;
                        tag_fill     = 0;
                        word_state   = PARSE_WORD;
                    end
                    else if (b == CH_LBRACKET)
                        word_state = PARSE_BRACKET;
                    else if (b == CH_BACKSLASH)
                        word_state = PARSE_TOP_ESC;
                    queue_result(b, 1'b1, STATUS_OK);
                end
                PARSE_TOP_ESC:
                begin
                    queue_result(b, 1'b1, STATUS_OK);
                    word_state = PARSE_TOP;
                end
                PARSE_BRACKET:
                begin
                    queue_result(b, 1'b1, STATUS_OK);
                    if (b == CH_RBRACKET)
                        word_state = PARSE_TOP;
                    else if (b == CH_BACKSLASH)
                        word_state = PARSE_BRACKET_ESC;
                end
                PARSE_BRACKET_ESC:
                begin
                    queue_result(b, 1'b1, STATUS_OK);
                    word_state = PARSE_BRACKET;
                end
                PARSE_WORD:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        for (int i = 0; i < tag_fill; i++)
                            queue_result(tag_store[i], 1'b1, STATUS_OK);
                        queue_result(CH_DOLLAR, 1'b1, STATUS_OK);
                        tag_fill   = 0;
                        span_open  = 1'b0;
                        word_state = PARSE_TOP;
                    end
                    else
                    begin
                        if (b == CH_LT && !span_open)
                            span_open = 1'b1;
                        else if (b == CH_HASH && span_open)
                            span_open = 1'b0;
                        if (span_open)
                        begin
                            if (b == CH_PLUS)
                            begin
                                store_tag_byte(CH_DOLLAR);
                                store_tag_byte(CH_SPACE);
                                store_tag_byte(CH_CARET);
                            end
                            else
                            begin
                                store_tag_byte(b);
                            end
                        end
                        else
                        begin
                            queue_result(b, 1'b1, STATUS_OK);
                        end
                    end
                end
                default:
                begin
                    word_state = PARSE_TOP;
                    queue_result(b, 1'b1, STATUS_OK);
                end
            endcase
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size()-1].last = 1'b1;
    endtask

    task automatic check_result();
        filter_result_t want;
        filter_result_t got;
        got.data_byte = dout.out_byte;
        got.is_data   = dout.is_data;
        got.last      = dout.last_of_run;
        got.status    = status_t'(dout.status);
        got.truncated = dout.truncated;
        if (expected_results.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected transfer: byte=%h data=%b last=%b status=%0d trunc=%b",
                     $time, got.data_byte, got.is_data, got.last, got.status,
                     got.truncated);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.data_byte !== want.data_byte || got.is_data !== want.is_data ||
                got.last !== want.last || got.status !== want.status ||
                got.truncated !== want.truncated)
            begin
                errors++;
                $display({"%0t: mismatch: expected byte=%h data=%b last=%b status=%0d ",
                          "trunc=%b, got byte=%h data=%b last=%b status=%0d trunc=%b"},
                         $time, want.data_byte, want.is_data, want.last, want.status,
                         want.truncated, got.data_byte, got.is_data, got.last,
                         got.status, got.truncated);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            if (din.valid && din.ready)
                predict_filter_output(din.in_byte, din.end_of_stream);
            if (dout.valid && dout.ready)
                check_result();
        end
        outstanding = expected_results.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for lexical_unit_tag_splitter_core: clock, reset, byte stimulus
// with idle and stall phases, and the final verdict.
// Depends on ltsp_pkg, the ltsp interfaces, the core and ltsp_result_monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ltsp_pkg::*;

    localparam int TAG_DEPTH   = TAG_BUF_DEPTH_DEF;
    localparam int ITEM_TARGET = 180;
    localparam int HOLD_CYCLES = 150;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   items_sent;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    bit   hold_request;

    ltsp_in_if  din_ch();
    ltsp_out_if dout_ch();

    lexical_unit_tag_splitter_core #(.TAG_BUFFER_DEPTH(TAG_DEPTH)) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din_ch),
        .dout (dout_ch)
    );

    ltsp_result_monitor #(.TAG_DEPTH(TAG_DEPTH)) result_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din_ch),
        .dout       (dout_ch),
        .errors     (errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lexical_unit_tag_splitter_core regression: fail");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        dout_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                dout_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                dout_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic bit is_marker(input logic [7:0] b);
        return b == CH_DOLLAR || b == CH_CARET || b == CH_LBRACKET || b == CH_RBRACKET ||
               b == CH_LT || b == CH_HASH || b == CH_PLUS || b == CH_BACKSLASH;
    endfunction

    // mostly non-marker bytes, sometimes anything
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if ($urandom_range(3) != 0)
            while (is_marker(b))
                b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic offer_item(input logic [7:0] b, input logic eos);
        din_ch.valid         <= 1'b1;
        din_ch.in_byte       <= b;
        din_ch.end_of_stream <= eos;
        do @(posedge clk); while (!din_ch.ready);
        items_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            din_ch.valid         <= 1'b0;
            din_ch.in_byte       <= 8'($urandom_range(255));
            din_ch.end_of_stream <= 1'($urandom_range(1));
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic feed(input logic [7:0] b);
        offer_item(b, 1'b0);
    endtask

    task automatic finish_stream();
        offer_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_word(input bit big, input bit broken);
        int spans;
        int len;
        feed(CH_CARET);
        repeat ($urandom_range(0, 3)) feed(plain_byte());
        spans = big ? 1 : $urandom_range(0, 2);
        repeat (spans)
        begin
            feed(CH_LT);
            len = big ? $urandom_range(12, 16) : $urandom_range(0, 5);
            repeat (len) feed(($urandom_range(2) == 0 || big) ? CH_PLUS : plain_byte());
            if ($urandom_range(4) != 0)
                feed(CH_HASH);
            repeat ($urandom_range(0, 2)) feed(plain_byte());
        end
        if (broken)
            finish_stream();
        else
            feed(CH_DOLLAR);
    endtask

    task automatic send_bracket(input bit broken);
        feed(CH_LBRACKET);
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(4) == 0)
            begin
                feed(CH_BACKSLASH);
                feed(8'($urandom_range(255)));
            end
            else
            begin
                feed(plain_byte());
            end
        end
        if (broken)
        begin
            if ($urandom_range(1))
                feed(CH_BACKSLASH);
            finish_stream();
        end
        else
        begin
            feed(CH_RBRACKET);
        end
    endtask

    task automatic send_random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            send_word($urandom_range(7) == 0, $urandom_range(9) == 0);
        end
        else if (pick < 70)
        begin
            send_bracket($urandom_range(7) == 0);
        end
        else if (pick < 85)
        begin
            repeat ($urandom_range(1, 3)) feed(plain_byte());
            if ($urandom_range(2) == 0)
            begin
                feed(CH_BACKSLASH);
                feed(8'($urandom_range(255)));
            end
            if ($urandom_range(3) == 0)
                finish_stream();
        end
        else
        begin
            // arbitrary bytes, then end of stream from whatever state results
            repeat ($urandom_range(1, 4)) feed(8'($urandom_range(255)));
            if ($urandom_range(1))
                feed(CH_BACKSLASH);
            finish_stream();
        end
    endtask

    initial
    begin
        int quota;
        int chunk;
        rst_n                <= 1'b0;
        din_ch.valid         <= 1'b0;
        din_ch.in_byte       <= 8'h00;
        din_ch.end_of_stream <= 1'b0;
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, escapes, brackets, span markers, ends of stream
        feed(8'h00);
        feed(8'hFF);
        feed(CH_BACKSLASH);
        feed(CH_CARET);
        feed(CH_LBRACKET);
        feed(CH_BACKSLASH);
        feed(CH_RBRACKET);
        feed(CH_RBRACKET);
        feed(CH_CARET);
        feed(CH_BACKSLASH);
        feed(CH_HASH);
        feed(CH_LT);
        feed(CH_LT);
        feed(CH_PLUS);
        feed(CH_HASH);
        feed(CH_DOLLAR);
        feed(CH_BACKSLASH);
        finish_stream();
        feed(CH_LBRACKET);
        feed(CH_BACKSLASH);
        finish_stream();
        feed(CH_CARET);
        feed(CH_LT);
        feed(8'h71);
        finish_stream();

        // tag buffer overflow
        send_word(1'b1, 1'b0);

        quota = items_sent;
        chunk = (ITEM_TARGET - items_sent) / 5;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:
                begin
                    sender_idle_pct = 75; receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 75; hold_request = 1'b1;
                end
                3:
                begin
                    sender_idle_pct = 28; receiver_stall_pct = 28;
                end
                default:
                begin
                    sender_idle_pct = 0; receiver_stall_pct = 0;
                end
            endcase
            quota += chunk;
            while (items_sent < quota)
                send_random_sequence();
        end

        din_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("lexical_unit_tag_splitter_core regression: pass");
        else
            $display("lexical_unit_tag_splitter_core regression: fail");
        $finish;
    end

endmodule
